FILE: rtl/core/civfr_pkg.sv
// Shared types and constants for the CI-V frame receiver/decoder.
// Used by every module under rtl/core; depends on nothing.
package civfr_pkg;

    localparam int BUF_DEPTH     = 32;
    localparam int LEN_W         = $clog2(BUF_DEPTH + 1);
    localparam int KEEP_BYTES    = 10;
    localparam int KEEP_IDX_W    = $clog2(KEEP_BYTES);
    localparam int BCD_BYTES     = 5;
    localparam int TDATA_W       = 56;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] END_BYTE      = 8'hFD;
    localparam logic [7:0] SUB_SMETER    = 8'h02;
    localparam logic [7:0] SUB_PTT       = 8'h00;
    localparam logic [7:0] MODE_LIMIT    = 8'd9;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(6);
    localparam logic [LEN_W-1:0] MIN_SHORT_LEN = LEN_W'(7);
    localparam logic [LEN_W-1:0] MIN_FREQ_LEN  = LEN_W'(10);

    // Frame byte positions
    localparam int POS_DEST = 2;
    localparam int POS_CMD  = 4;
    localparam int POS_DATA = 5;

    localparam logic [31:0] DIGIT_WEIGHT [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    typedef enum logic [2:0] {
        CFG_CTRL_ADDR  = 3'd0,
        CFG_FREQ_READ  = 3'd1,
        CFG_FREQ_SET   = 3'd2,
        CFG_MODE_READ  = 3'd3,
        CFG_MODE_SET   = 3'd4,
        CFG_LEVEL_READ = 3'd5,
        CFG_TX_STATUS  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_FREQ   = 2'd0,
        KIND_MODE   = 2'd1,
        KIND_SMETER = 2'd2,
        KIND_PTT    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] ctrl_addr;
        logic [7:0] freq_read;
        logic [7:0] freq_set;
        logic [7:0] mode_read;
        logic [7:0] mode_set;
        logic [7:0] level_read;
        logic [7:0] tx_status;
    } cfg_t;

    // Snapshot of a closed frame: length and the bytes the decoder reads
    typedef struct packed {
        logic                           valid;
        logic [LEN_W-1:0]               len;
        logic [7:0]                     dest;
        logic [7:0]                     cmd;
        logic [BCD_BYTES-1:0][7:0]      data;
    } frame_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] frequency_hz;
        logic [7:0]  mode_code;
        logic        mode_known;
        logic [7:0]  smeter_level;
        logic        ptt_on;
    } result_t;

endpackage

FILE: rtl/core/civfr_cfg.sv
// Configuration register bank for the CI-V frame receiver/decoder.
// Depends on civfr_pkg.
module civfr_cfg import civfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg_o
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_o     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CTRL_ADDR:  cfg_next.ctrl_addr  = cfg_data;
                CFG_FREQ_READ:  cfg_next.freq_read  = cfg_data;
                CFG_FREQ_SET:   cfg_next.freq_set   = cfg_data;
                CFG_MODE_READ:  cfg_next.mode_read  = cfg_data;
                CFG_MODE_SET:   cfg_next.mode_set   = cfg_data;
                CFG_LEVEL_READ: cfg_next.level_read = cfg_data;
                CFG_TX_STATUS:  cfg_next.tx_status  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ctrl_addr  <= 8'hE0;
            cfg_reg.freq_read  <= 8'h03;
            cfg_reg.freq_set   <= 8'h05;
            cfg_reg.mode_read  <= 8'h04;
            cfg_reg.mode_set   <= 8'h06;
            cfg_reg.level_read <= 8'h15;
            cfg_reg.tx_status  <= 8'h1C;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/civfr_tracker.sv
// Frame tracker: preamble detection, byte buffer and frame length.
// Emits a snapshot of each closed frame. Depends on civfr_pkg.
module civfr_tracker import civfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_fire,
    input  logic [7:0] rx_byte,
    output frame_t     close_o
);

    logic [7:0]       buf_reg  [KEEP_BYTES];
    logic [7:0]       buf_next [KEEP_BYTES];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_put;
    logic             in_frame_reg;
    logic             in_frame_next;
    logic             is_pre;
    logic             is_end;
    logic             do_put;
    logic             do_store;

    assign is_pre   = (rx_byte == PREAMBLE_BYTE);
    assign is_end   = (rx_byte == END_BYTE);
    assign do_put   = byte_fire && !is_pre && in_frame_reg;
    assign do_store = do_put && (len_reg < LEN_W'(KEEP_BYTES));
    // Length saturates at the buffer size
    assign len_put  = (len_reg < LEN_W'(BUF_DEPTH)) ? len_reg + LEN_W'(1) : len_reg;

    always_comb begin
        buf_next      = buf_reg;
        len_next      = len_reg;
        in_frame_next = in_frame_reg;
        if (byte_fire && is_pre) begin
            buf_next[0] = PREAMBLE_BYTE;
            if (len_reg != '0) begin
                // Preamble pending: open or restart the frame
                buf_next[1]   = PREAMBLE_BYTE;
                len_next      = LEN_W'(2);
                in_frame_next = 1'b1;
            end else begin
                len_next = LEN_W'(1);
            end
        end else if (do_put) begin
            if (do_store) begin
                buf_next[len_reg[KEEP_IDX_W-1:0]] = rx_byte;
            end
            len_next = len_put;
            if (is_end) begin
                len_next      = '0;
                in_frame_next = 1'b0;
            end
        end
    end

    always_comb begin
        close_o.valid = do_put && is_end;
        close_o.len   = len_put;
        close_o.dest  = buf_next[POS_DEST];
        close_o.cmd   = buf_next[POS_CMD];
        for (int i = 0; i < BCD_BYTES; i++) begin
            close_o.data[i] = buf_next[POS_DATA + i];
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            in_frame_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            in_frame_reg <= in_frame_next;
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(BUF_DEPTH))
        else $error("frame length above buffer size");

    a_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (len_reg >= LEN_W'(2)))
        else $error("open frame without both preamble bytes");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        close_o.valid |=> (len_reg == '0 && !in_frame_reg))
        else $error("frame state not cleared after close");

endmodule

FILE: rtl/core/civfr_decode.sv
// Frame decoder: registered closed-frame snapshot, command decode and
// BCD sum, result register with handshake. Depends on civfr_pkg.
module civfr_decode import civfr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg_i,
    input  frame_t  close_i,
    output logic    in_ready,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_o
);

    logic    d_valid_reg;
    logic    d_valid_next;
    frame_t  d_frame_reg;
    logic    m_valid_reg;
    logic    m_valid_next;
    result_t m_res_reg;
    result_t dec_res;
    logic    dec_hit;
    logic    m_free;
    logic    d_free;
    logic    addr_ok;
    logic    is_freq;
    logic    is_mode;
    logic    is_level;
    logic    is_tx;
    logic    short_ok;
    logic [31:0] bcd_sum;

    assign m_free    = !m_valid_reg || res_ready;
    assign d_free    = !d_valid_reg || m_free;
    assign in_ready  = d_free;
    assign res_valid = m_valid_reg;
    assign res_o     = m_res_reg;

    assign addr_ok  = (d_frame_reg.len >= MIN_FRAME_LEN) &&
                      (d_frame_reg.dest == cfg_i.ctrl_addr);
    assign is_freq  = (d_frame_reg.cmd == cfg_i.freq_read) ||
                      (d_frame_reg.cmd == cfg_i.freq_set);
    assign is_mode  = (d_frame_reg.cmd == cfg_i.mode_read) ||
                      (d_frame_reg.cmd == cfg_i.mode_set);
    assign is_level = (d_frame_reg.cmd == cfg_i.level_read);
    assign is_tx    = (d_frame_reg.cmd == cfg_i.tx_status);
    assign short_ok = (d_frame_reg.len >= MIN_SHORT_LEN);

    // Constant weights reduce to shift-add trees
    always_comb begin
        bcd_sum = '0;
        for (int i = 0; i < BCD_BYTES; i++) begin
            bcd_sum = bcd_sum
                + 32'(d_frame_reg.data[i][3:0] & NIBBLE_MASK) * DIGIT_WEIGHT[2*i]
                + 32'(d_frame_reg.data[i][7:4] & NIBBLE_MASK) * DIGIT_WEIGHT[2*i+1];
        end
    end

    always_comb begin
        dec_res = '0;
        dec_hit = 1'b0;
        if (addr_ok) begin
            priority if (is_freq) begin
                dec_hit              = (d_frame_reg.len >= MIN_FREQ_LEN);
                dec_res.kind         = KIND_FREQ;
                dec_res.frequency_hz = bcd_sum;
            end else if (is_mode) begin
                dec_hit            = short_ok;
                dec_res.kind       = KIND_MODE;
                dec_res.mode_code  = d_frame_reg.data[0];
                dec_res.mode_known = (d_frame_reg.data[0] < MODE_LIMIT);
            end else if (is_level) begin
                dec_hit              = short_ok && (d_frame_reg.data[0] == SUB_SMETER);
                dec_res.kind         = KIND_SMETER;
                dec_res.smeter_level = d_frame_reg.data[1];
            end else if (is_tx) begin
                dec_hit        = short_ok && (d_frame_reg.data[0] == SUB_PTT);
                dec_res.kind   = KIND_PTT;
                dec_res.ptt_on = (d_frame_reg.data[1] != 8'h00);
            end else begin
                dec_hit = 1'b0;
            end
        end
    end

    assign d_valid_next = d_free ? close_i.valid : d_valid_reg;
    assign m_valid_next = m_free ? (d_valid_reg && dec_hit) : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (d_free && close_i.valid) begin
            d_frame_reg <= close_i;
        end
        if (m_free) begin
            m_res_reg <= dec_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(d_valid_reg))
        else $error("result appeared without a closed frame");

endmodule

FILE: rtl/core/civ_frame_receiver_decoder.sv
// Top level of the CI-V frame receiver/decoder: config bank, frame tracker
// and decoder. Depends on civfr_pkg, civfr_cfg, civfr_tracker, civfr_decode.
//
//  Channel  Direction  Payload
//  s_       in         tdata[7:0] rx_byte
//  m_       out        tuser[1:0] update_kind; tdata frequency_hz, mode_code,
//                      mode_known, smeter_level, ptt_on
//  cfg_     in         cfg_index[2:0] register, cfg_data[7:0] value
//
// One byte is accepted per cycle while s_tready is high. A closing end byte's
// frame is registered in the frame snapshot register, then passes through the
// decode and BCD sum into the result register.
// Reset (aresetn low, synchronous) clears frame state and valids; config to defaults.
// A stalled result holds in the result register while one more closed frame
// waits in the snapshot register; only then does s_tready drop.
module civ_frame_receiver_decoder import civfr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] frequency_hz, [39:32] mode_code,
                                          // [40] mode_known, [48:41] smeter_level,
                                          // [49] ptt_on, [55:50] zero
    output logic [1:0]         m_tuser,   // [1:0] update_kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cfg_t    cfg;
    frame_t  close_frame;
    result_t res;
    logic    byte_fire;

    assign byte_fire = s_tvalid && s_tready;

    civfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    civfr_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .close_o   (close_frame)
    );

    civfr_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg),
        .close_i   (close_frame),
        .in_ready  (s_tready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_o     (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {6'b0, res.ptt_on, res.smeter_level, res.mode_known,
                      res.mode_code, res.frequency_hz};

endmodule
